/* rtl/core/hbp_pkg.sv */
// Shared types, constants and datapath command codes for the block profiler.
package hbp_pkg;

    localparam int ANCHOR_W     = 12;
    localparam int ANCHOR_COUNT = 1 << ANCHOR_W;
    localparam int STACK_DEPTH  = 64;
    localparam int STACK_AW     = $clog2(STACK_DEPTH);
    localparam int LEVEL_W      = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W        = 12;
    localparam int BYTES_W      = 32;
    localparam int TIME_W       = 64;
    localparam int ACC_W        = 64;

    typedef enum logic [1:0] {
        REQ_BEGIN = 2'd0,
        REQ_END   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [IDX_W-1:0]   anchor_index;
        logic [BYTES_W-1:0] byte_count;
        logic [TIME_W-1:0]  timestamp;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [ACC_W-1:0] exclusive_time;
        logic [ACC_W-1:0] inclusive_time;
        logic [ACC_W-1:0] hit_count;
        logic [ACC_W-1:0] byte_total;
    } t_out_item;

    typedef struct packed {
        logic [ACC_W-1:0] excl;
        logic [ACC_W-1:0] incl;
        logic [ACC_W-1:0] hits;
        logic [ACC_W-1:0] bytes;
    } t_anchor_row;

    typedef struct packed {
        logic [ANCHOR_W-1:0] parent;
        logic [ANCHOR_W-1:0] anchor;
        logic [ACC_W-1:0]    old_incl;
        logic [TIME_W-1:0]   start;
    } t_frame;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LATCH,
        DP_RD_IDX,
        DP_BEGIN_WR,
        DP_FRAME_RD,
        DP_PAR_RD,
        DP_PAR_WR,
        DP_ANC_RD,
        DP_ANC_WR,
        DP_LOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic stack_full;
        logic stack_empty;
    } t_dp_stat;

endpackage

/* rtl/core/hierarchical_block_profiler.sv */
// Top level of the hierarchical block profiler with inclusive and exclusive timing.
// The input channel takes one transaction per request: begin block, end block or
// read anchor, with an anchor index, a byte count and a timestamp. The output
// channel returns exactly one transaction per request with a status and, for a
// read, the anchor's exclusive time, inclusive time, hit count and byte total.
// One request is worked on at a time; the anchor table has a single port, so an
// end request, which rewrites both the parent and the anchor, takes the longest.
// After acceptance a begin reads and writes its anchor row; an end reads the
// frame, reads and writes the parent, then reads and writes the anchor; a read
// reads the anchor row; an overflow, underflow or unused type goes straight to
// the result load. The next request is accepted in the cycle after that load.
// After reset the 4096 anchor rows are zeroed one row per cycle, and no request
// is accepted until that pass is over. The result sits in an output register;
// while the receiver stalls, the next request is still accepted and processed,
// and the block waits only when a second result is ready to be loaded.
module hierarchical_block_profiler
    import hbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    hbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_in.req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    hbp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_out   (o_out)
    );

endmodule

/* rtl/core/hbp_dp.sv */
// Datapath of the block profiler: anchor table, frame stack and result register.
module hbp_dp
    import hbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_item o_out
);

    t_anchor_row r_anchor_mem [ANCHOR_COUNT];
    t_frame      r_frame_mem  [STACK_DEPTH];

    t_anchor_row r_anc_q;
    t_frame      r_frame_q;
    t_out_item   r_result;

    t_req                r_req;
    logic [ANCHOR_W-1:0] r_idx;
    logic [BYTES_W-1:0]  r_bytes;
    logic [TIME_W-1:0]   r_ts;
    logic [ANCHOR_W-1:0] r_par;
    logic [ANCHOR_W-1:0] r_anc;
    logic [ACC_W-1:0]    r_old_incl;
    logic [ACC_W-1:0]    r_elapsed;

    logic [LEVEL_W-1:0]  r_level;
    logic [ANCHOR_W-1:0] r_parent;
    logic [ANCHOR_W-1:0] r_clr_addr;

    logic                anc_re;
    logic [ANCHOR_W-1:0] anc_raddr;
    logic                anc_we;
    logic [ANCHOR_W-1:0] anc_waddr;
    t_anchor_row         anc_wdata;
    logic                frame_re;
    logic                frame_we;
    logic [STACK_AW-1:0] frame_raddr;
    logic [STACK_AW-1:0] frame_waddr;
    t_frame              frame_wdata;

    assign frame_raddr = STACK_AW'(r_level - LEVEL_W'(1));
    assign frame_waddr = STACK_AW'(r_level);
    assign frame_wdata = '{parent: r_parent, anchor: r_idx, old_incl: r_anc_q.incl, start: r_ts};

    always_comb begin
        anc_re    = 1'b0;
        anc_raddr = r_idx;
        anc_we    = 1'b0;
        anc_waddr = r_idx;
        anc_wdata = r_anc_q;
        frame_re  = 1'b0;
        frame_we  = 1'b0;
        unique case (i_cmd.op)
            DP_CLEAR: begin
                anc_we    = 1'b1;
                anc_waddr = r_clr_addr;
                anc_wdata = '0;
            end
            DP_RD_IDX: begin
                anc_re = 1'b1;
            end
            DP_BEGIN_WR: begin
                anc_we          = 1'b1;
                anc_wdata.bytes = r_anc_q.bytes + ACC_W'(r_bytes);
                frame_we        = 1'b1;
            end
            DP_FRAME_RD: begin
                frame_re = 1'b1;
            end
            DP_PAR_RD: begin
                anc_re    = 1'b1;
                anc_raddr = r_frame_q.parent;
            end
            DP_PAR_WR: begin
                anc_we         = 1'b1;
                anc_waddr      = r_par;
                anc_wdata.excl = r_anc_q.excl - r_elapsed;
            end
            DP_ANC_RD: begin
                anc_re    = 1'b1;
                anc_raddr = r_anc;
            end
            DP_ANC_WR: begin
                anc_we         = 1'b1;
                anc_waddr      = r_anc;
                anc_wdata.excl = r_anc_q.excl + r_elapsed;
                anc_wdata.incl = r_old_incl + r_elapsed;
                anc_wdata.hits = r_anc_q.hits + ACC_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (anc_we) begin
            r_anchor_mem[anc_waddr] <= anc_wdata;
        end
        if (anc_re) begin
            r_anc_q <= r_anchor_mem[anc_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            r_frame_mem[frame_waddr] <= frame_wdata;
        end
        if (frame_re) begin
            r_frame_q <= r_frame_mem[frame_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= '0;
            r_parent   <= '0;
            r_clr_addr <= '0;
        end else begin
            unique case (i_cmd.op)
                DP_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ANCHOR_W'(1);
                end
                DP_BEGIN_WR: begin
                    r_level  <= r_level + LEVEL_W'(1);
                    r_parent <= r_idx;
                end
                DP_FRAME_RD: begin
                    r_level <= r_level - LEVEL_W'(1);
                end
                DP_PAR_RD: begin
                    r_parent <= r_frame_q.parent;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LATCH: begin
                r_req   <= t_req'(i_in.req_type);
                r_idx   <= ANCHOR_W'(i_in.anchor_index);
                r_bytes <= i_in.byte_count;
                r_ts    <= i_in.timestamp;
            end
            DP_PAR_RD: begin
                r_par      <= r_frame_q.parent;
                r_anc      <= r_frame_q.anchor;
                r_old_incl <= r_frame_q.old_incl;
                r_elapsed  <= r_ts - r_frame_q.start;
            end
            DP_LOAD: begin
                r_result.status <= i_cmd.status;
                if (r_req == REQ_READ) begin
                    r_result.exclusive_time <= r_anc_q.excl;
                    r_result.inclusive_time <= r_anc_q.incl;
                    r_result.hit_count      <= r_anc_q.hits;
                    r_result.byte_total     <= r_anc_q.bytes;
                end else begin
                    r_result.exclusive_time <= '0;
                    r_result.inclusive_time <= '0;
                    r_result.hit_count      <= '0;
                    r_result.byte_total     <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.clear_last  = (r_clr_addr == '1);
    assign o_stat.stack_full  = (r_level == LEVEL_W'(STACK_DEPTH));
    assign o_stat.stack_empty = (r_level == '0);
    assign o_out              = r_result;

endmodule

/* rtl/core/hbp_ctrl.sv */
// Controller of the block profiler: sequences each transaction and owns both handshakes.
module hbp_ctrl
    import hbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BEG_RD,
        S_BEG_WR,
        S_END_FRD,
        S_END_PRD,
        S_END_PWR,
        S_END_ARD,
        S_END_AWR,
        S_RD_RD,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_status r_status;
    t_status n_status;
    logic    r_out_valid;
    logic    n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_in_ready   = 1'b0;
        o_cmd.op     = DP_NOP;
        o_cmd.status = r_status;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = DP_CLEAR;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = DP_LATCH;
                    n_status = ST_OK;
                    unique case (t_req'(i_req_type))
                        REQ_BEGIN: begin
                            if (i_stat.stack_full) begin
                                n_status = ST_OVERFLOW;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_BEG_RD;
                            end
                        end
                        REQ_END: begin
                            if (i_stat.stack_empty) begin
                                n_status = ST_UNDERFLOW;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_END_FRD;
                            end
                        end
                        REQ_READ: begin
                            n_state = S_RD_RD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_BEG_RD: begin
                o_cmd.op = DP_RD_IDX;
                n_state  = S_BEG_WR;
            end
            S_BEG_WR: begin
                o_cmd.op = DP_BEGIN_WR;
                n_state  = S_DONE;
            end
            S_END_FRD: begin
                o_cmd.op = DP_FRAME_RD;
                n_state  = S_END_PRD;
            end
            S_END_PRD: begin
                o_cmd.op = DP_PAR_RD;
                n_state  = S_END_PWR;
            end
            S_END_PWR: begin
                o_cmd.op = DP_PAR_WR;
                n_state  = S_END_ARD;
            end
            S_END_ARD: begin
                o_cmd.op = DP_ANC_RD;
                n_state  = S_END_AWR;
            end
            S_END_AWR: begin
                o_cmd.op = DP_ANC_WR;
                n_state  = S_DONE;
            end
            S_RD_RD: begin
                o_cmd.op = DP_RD_IDX;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = DP_LOAD;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* tb/hierarchical_block_profiler_test.sv */
// Self-checking testbench for the hierarchical block profiler.
`timescale 1ns / 100ps

module hierarchical_block_profiler_test;
    import hbp_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;

    hierarchical_block_profiler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #1 i_clk = ~i_clk;

    logic [ACC_W-1:0]    tally_excl  [ANCHOR_COUNT];
    logic [ACC_W-1:0]    tally_incl  [ANCHOR_COUNT];
    logic [ACC_W-1:0]    tally_hits  [ANCHOR_COUNT];
    logic [ACC_W-1:0]    tally_bytes [ANCHOR_COUNT];
    logic [ANCHOR_W-1:0] tally_parent;
    t_frame              tally_frames [STACK_DEPTH];
    int                  tally_level;

    t_out_item        reply_q [$];
    int               mismatch_count = 0;
    bit               in_idle_on = 1'b0;
    bit               out_idle_on = 1'b0;
    int               out_gap = 0;
    int               hold_len = 0;
    logic [TIME_W-1:0] tick_now = '0;

    function automatic t_out_item profile_step(t_in_item it);
        t_out_item         r;
        t_frame            fr;
        logic [TIME_W-1:0] elapsed;
        logic [IDX_W-1:0]  idx;
        r = '0;
        idx = it.anchor_index;
        r.status = ST_OK;
        case (t_req'(it.req_type))
            REQ_BEGIN: begin
                if (tally_level >= STACK_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    fr.parent   = tally_parent;
                    fr.anchor   = idx;
                    fr.old_incl = tally_incl[idx];
                    fr.start    = it.timestamp;
                    tally_frames[tally_level] = fr;
                    tally_level++;
                    tally_bytes[idx] += ACC_W'(it.byte_count);
                    tally_parent = idx;
                end
            end
            REQ_END: begin
                if (tally_level == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    tally_level--;
                    fr = tally_frames[tally_level];
                    elapsed = it.timestamp - fr.start;
                    tally_parent = fr.parent;
                    tally_excl[fr.parent] -= elapsed;
                    tally_excl[fr.anchor] += elapsed;
                    tally_incl[fr.anchor] = fr.old_incl + elapsed;
                    tally_hits[fr.anchor] += 1;
                end
            end
            REQ_READ: begin
                r.exclusive_time = tally_excl[idx];
                r.inclusive_time = tally_incl[idx];
                r.hit_count      = tally_hits[idx];
                r.byte_total     = tally_bytes[idx];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_in_item make_item(t_req kind, logic [IDX_W-1:0] a,
                                           logic [BYTES_W-1:0] b, logic [TIME_W-1:0] ts);
        t_in_item it;
        it.req_type     = kind;
        it.anchor_index = a;
        it.byte_count   = b;
        it.timestamp    = ts;
        return it;
    endfunction

    function automatic logic [IDX_W-1:0] pick_anchor();
        if ($urandom_range(0, 3) == 0)
            return IDX_W'($urandom);
        return IDX_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [TIME_W-1:0] next_tick();
        if ($urandom_range(0, 29) == 0)
            tick_now = {$urandom, $urandom};
        else
            tick_now += TIME_W'($urandom_range(0, 2000));
        return tick_now;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < 40)
            $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(t_in_item it);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        reply_q.push_back(profile_step(it));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (reply_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_extremes();
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        send_item(make_item(REQ_READ, '0, '0, '0));
        send_item(make_item(REQ_READ, '1, '1, '1));
        send_item(make_item(REQ_END, 12'h555, 32'h5555_5555, 64'h5555_5555_5555_5555));
        send_item(make_item(REQ_NONE, '1, '1, '1));
        send_item(make_item(REQ_BEGIN, '1, '1, 64'hFFFF_FFFF_FFFF_FFF0));
        send_item(make_item(REQ_BEGIN, '1, '1, 64'h10));
        send_item(make_item(REQ_BEGIN, '0, '0, 64'h20));
        send_item(make_item(REQ_READ, '1, '0, '0));
        send_item(make_item(REQ_END, 12'hAAA, 32'hAAAA_AAAA, 64'h30));
        send_item(make_item(REQ_END, '0, '0, 64'h5));
        send_item(make_item(REQ_END, '0, '0, 64'h0));
        send_item(make_item(REQ_END, '1, '1, '1));
        send_item(make_item(REQ_READ, '1, '0, '0));
        send_item(make_item(REQ_READ, '0, '0, '0));
        send_item(make_item(REQ_NONE, 12'hAAA, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
        send_item(make_item(REQ_BEGIN, 12'h555, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555));
        send_item(make_item(REQ_END, 12'hAAA, '0, 64'hAAAA_AAAA_AAAA_AAAA));
        send_item(make_item(REQ_READ, 12'h555, '0, '0));
        wait_drained();
    endtask

    task automatic test_stack_limits();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b1;
        repeat (STACK_DEPTH)
            send_item(make_item(REQ_BEGIN, pick_anchor(), BYTES_W'($urandom), next_tick()));
        send_item(make_item(REQ_BEGIN, pick_anchor(), BYTES_W'($urandom), next_tick()));
        send_item(make_item(REQ_BEGIN, '1, '1, '1));
        send_item(make_item(REQ_READ, pick_anchor(), '0, '0));
        repeat (STACK_DEPTH)
            send_item(make_item(REQ_END, pick_anchor(), BYTES_W'($urandom), next_tick()));
        send_item(make_item(REQ_END, pick_anchor(), BYTES_W'($urandom), next_tick()));
        repeat (4) send_item(make_item(REQ_READ, pick_anchor(), '0, '0));
        wait_drained();
    endtask

    task automatic test_random_nesting(int count, int begin_pct, bit in_idle, bit out_idle);
        int       done;
        int       r;
        t_in_item it;
        in_idle_on  = in_idle;
        out_idle_on = out_idle;
        done = 0;
        while (done < count) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                it = make_item(REQ_NONE, IDX_W'($urandom), BYTES_W'($urandom),
                               {$urandom, $urandom});
            else if (r < 5 + begin_pct)
                it = make_item(REQ_BEGIN, pick_anchor(), BYTES_W'($urandom), next_tick());
            else if (r < 85)
                it = make_item(REQ_END, IDX_W'($urandom), BYTES_W'($urandom), next_tick());
            else
                it = make_item(REQ_READ, pick_anchor(), BYTES_W'($urandom),
                               {$urandom, $urandom});
            done++;
            send_item(it);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        hold_len    = 300;
        repeat (20) begin
            if ($urandom_range(0, 1) == 0)
                send_item(make_item(REQ_READ, pick_anchor(), '0, '0));
            else
                send_item(make_item(REQ_BEGIN, pick_anchor(), BYTES_W'($urandom), next_tick()));
        end
        wait_drained();
        repeat (20)
            send_item(make_item(REQ_END, pick_anchor(), BYTES_W'($urandom), next_tick()));
        wait_drained();
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                hold_len--;
                i_out_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= i_rst_n;
            end
        end
    end

    initial begin
        t_out_item got;
        t_out_item want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got = o_out;
                if (reply_q.size() == 0) begin
                    report_mismatch("unexpected transaction", got.status, '0);
                end else begin
                    want = reply_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.exclusive_time !== want.exclusive_time)
                        report_mismatch("exclusive_time", got.exclusive_time,
                                        want.exclusive_time);
                    if (got.inclusive_time !== want.inclusive_time)
                        report_mismatch("inclusive_time", got.inclusive_time,
                                        want.inclusive_time);
                    if (got.hit_count !== want.hit_count)
                        report_mismatch("hit_count", got.hit_count, want.hit_count);
                    if (got.byte_total !== want.byte_total)
                        report_mismatch("byte_total", got.byte_total, want.byte_total);
                end
                out_gap = out_idle_on ? $urandom_range(0, 14) : 0;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("hierarchical_block_profiler verification failed");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        for (int i = 0; i < ANCHOR_COUNT; i++) begin
            tally_excl[i]  = '0;
            tally_incl[i]  = '0;
            tally_hits[i]  = '0;
            tally_bytes[i] = '0;
        end
        tally_parent = '0;
        tally_level  = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_stack_limits();
        test_random_nesting(400, 40, 1'b1, 1'b1);
        test_random_nesting(300, 38, 1'b0, 1'b0);
        test_backpressure();
        test_random_nesting(300, 70, 1'b1, 1'b0);
        test_random_nesting(300, 38, 1'b0, 1'b1);
        test_random_nesting(400, 42, 1'b1, 1'b1);

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("hierarchical_block_profiler verification clean");
        else
            $display("hierarchical_block_profiler verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/hbp_pkg.sv
rtl/core/hbp_dp.sv
rtl/core/hbp_ctrl.sv
rtl/core/hierarchical_block_profiler.sv
tb/hierarchical_block_profiler_test.sv
